@@ src/running_variance_merge_core_macros.svh @@
// Assertion macros for the running variance merge core.
`ifndef RUNNING_VARIANCE_MERGE_CORE_MACROS_SVH
`define RUNNING_VARIANCE_MERGE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Implication or plain property, checked at every rising edge outside reset.
`define RVM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Condition that must never hold.
`define RVM_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define RVM_ASSERT(lbl, clk, rst_n, prop, msg)
`define RVM_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ src/rvm_pkg.sv @@
// Constants shared by the running variance merge core and its interfaces.
package rvm_pkg;
    localparam int COUNT_WIDTH   = 48;
    localparam int FRAC_BITS     = 16;
    localparam int M2_FRAC       = 8;
    localparam int ALIGN_SHIFT   = 2 * FRAC_BITS - M2_FRAC;
    localparam int OUT_COUNT_W   = 48;
    localparam int FIELD_W       = 32;
    localparam int M2_W          = 64;
    localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = '1;
endpackage

@@ src/rvm_if.sv @@
// Valid/ready channel interfaces for partition input and total output.
interface rvm_in_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [rvm_pkg::FIELD_W-1:0]  partition_count;
    logic [rvm_pkg::FIELD_W-1:0]  partition_mean;
    logic [rvm_pkg::FIELD_W-1:0]  partition_stddev;

    modport source (output valid, operation, partition_count, partition_mean,
                    partition_stddev, input ready);
    modport sink   (input valid, operation, partition_count, partition_mean,
                    partition_stddev, output ready);
endinterface

interface rvm_out_if;
    logic                            valid;
    logic                            ready;
    logic [rvm_pkg::OUT_COUNT_W-1:0] total_count;
    logic [rvm_pkg::FIELD_W-1:0]     total_mean;
    logic [rvm_pkg::FIELD_W-1:0]     total_stddev;
    logic                            saturated;

    modport source (output valid, total_count, total_mean, total_stddev, saturated,
                    input ready);
    modport sink   (input valid, total_count, total_mean, total_stddev, saturated,
                    output ready);
endinterface

@@ src/running_variance_merge_core.sv @@
// Running variance merge core: folds partition (count, mean, stddev) into running totals.
// Each transaction either clears the totals or merges one partition by the pairwise
// parallel-variance combine, then returns count, mean (Q16.16) and sample stddev
// (Q16.16, zero below two samples). Work is done by one 32x32 multiplier, one
// bit-serial restoring divider and one bit-serial square root under a sequencer,
// one transaction at a time. A clear goes straight to the result; an empty partition
// only recomputes the stddev and the first partition after a clear first forms its
// M2; a full merge runs seven multiplies, divides of 64, 80 and 112 steps, an
// 88-step variance divide and a 44-step root. No new transaction is accepted until
// the result has been taken.
`include "running_variance_merge_core_macros.svh"

module running_variance_merge_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rvm_in_if.sink   i_in,
    rvm_out_if.source o_out
);
    localparam int CW     = rvm_pkg::COUNT_WIDTH;
    localparam int AS     = rvm_pkg::ALIGN_SHIFT;
    localparam int DW     = 128;
    localparam int SQ_W   = rvm_pkg::M2_W + AS;
    localparam int RT_W   = SQ_W / 2;
    localparam int SR_W   = RT_W + 2;
    localparam int CNT_W  = $clog2(DW + 1);
    localparam int FW     = rvm_pkg::FIELD_W;
    localparam logic [2:0] MUL_STEPS = 3'd4;

    // Sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MUL  = 5'd1;
    localparam logic [4:0] S_DIV  = 5'd2;
    localparam logic [4:0] S_SQRT = 5'd3;
    localparam logic [4:0] S_P2   = 5'd4;
    localparam logic [4:0] S_P3   = 5'd5;
    localparam logic [4:0] S_M1   = 5'd6;
    localparam logic [4:0] S_M2   = 5'd7;
    localparam logic [4:0] S_M3   = 5'd8;
    localparam logic [4:0] S_M4   = 5'd9;
    localparam logic [4:0] S_M5   = 5'd10;
    localparam logic [4:0] S_M6   = 5'd11;
    localparam logic [4:0] S_M7   = 5'd12;
    localparam logic [4:0] S_M8   = 5'd13;
    localparam logic [4:0] S_M9   = 5'd14;
    localparam logic [4:0] S_VAR  = 5'd15;
    localparam logic [4:0] S_V2   = 5'd16;
    localparam logic [4:0] S_FIN  = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    // Truncating shift by the alignment amount, saturating to 64 bits
    function automatic logic [64:0] sat_shift(input logic [DW-1:0] x);
        logic [64:0] r;
        if (x[DW-1:64+AS] != '0) begin
            r = {1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
        end else begin
            r = {1'b0, x[63+AS:AS]};
        end
        return r;
    endfunction

    // Saturating 64-bit add
    function automatic logic [64:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        logic [64:0] r;
        s = {1'b0, a} + {1'b0, b};
        if (s[64]) begin
            r = {1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
        end else begin
            r = s;
        end
        return r;
    endfunction

    // Architectural state
    logic [4:0]      r_state;
    logic [4:0]      r_ret;
    logic [CW-1:0]   r_count;
    logic [FW-1:0]   r_mean;
    logic [63:0]     r_sq;
    logic            r_sat;

    // Working registers
    logic [FW-1:0]   r_n, r_pm, r_ad, r_ratio, r_sd;
    logic            r_neg;
    logic [CW-1:0]   r_newc;
    logic [63:0]     r_t1, r_ext, r_pm2;

    // Multiplier
    logic [63:0]     r_ma, r_mb, r_pp;
    logic [2:0]      r_mcnt;
    logic [1:0]      r_psh;
    logic [DW-1:0]   r_prod;

    // Divider and square root
    logic [DW-1:0]   r_dvd, r_q;
    logic [CW-1:0]   r_dv, r_drem;
    logic [CNT_W-1:0] r_cnt;
    logic [SR_W-1:0] r_srem;
    logic [RT_W-1:0] r_root;

    logic            accept;
    logic [FW-1:0]   a_part, b_part;
    logic [1:0]      psh;
    logic [DW-1:0]   pp_shifted;
    logic [CW:0]     drs, ddiff;
    logic            dge;
    logic [SR_W-1:0] ss, strial, sdiff;
    logic            sge;
    logic [64:0]     pm2_sat, term_sat, sq_sum;
    logic [CW:0]     csum;
    logic [FW-1:0]   ad;
    logic            neg;

    assign accept = i_in.valid && i_in.ready;

    // Partial-product selection
    assign a_part = r_mcnt[1] ? r_ma[63:32] : r_ma[31:0];
    assign b_part = r_mcnt[0] ? r_mb[63:32] : r_mb[31:0];
    assign psh    = {1'b0, r_mcnt[1]} + {1'b0, r_mcnt[0]};

    always_comb begin
        case (r_psh)
            2'd0:    pp_shifted = {64'b0, r_pp};
            2'd1:    pp_shifted = {32'b0, r_pp, 32'b0};
            default: pp_shifted = {r_pp, 64'b0};
        endcase
    end

    // Restoring divide step
    assign drs   = {r_drem, r_dvd[DW-1]};
    assign ddiff = drs - {1'b0, r_dv};
    assign dge   = drs >= {1'b0, r_dv};

    // Digit-by-digit square root step
    assign ss     = {r_srem[SR_W-3:0], r_dvd[DW-1:DW-2]};
    assign strial = {r_root, 2'b01};
    assign sge    = ss >= strial;
    assign sdiff  = ss - strial;

    // Merge helpers
    assign pm2_sat  = sat_shift(r_prod);
    assign term_sat = sat_shift(r_prod + {64'b0, r_ext});
    assign sq_sum   = add_sat(r_sq, r_pm2);
    assign csum     = {1'b0, r_count} + (CW + 1)'(r_n);
    assign neg      = r_pm < r_mean;
    assign ad       = neg ? (r_mean - r_pm) : (r_pm - r_mean);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_mean  <= '0;
            r_sq    <= '0;
            r_sat   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_n  <= i_in.partition_count;
                        r_pm <= i_in.partition_mean;
                        if (i_in.operation) begin
                            r_count <= '0;
                            r_mean  <= '0;
                            r_sq    <= '0;
                            r_sat   <= 1'b0;
                            r_sd    <= '0;
                            r_state <= S_OUT;
                        end else if (i_in.partition_count == '0) begin
                            r_state <= S_VAR;
                        end else begin
                            r_ma    <= 64'(i_in.partition_stddev);
                            r_mb    <= 64'(i_in.partition_stddev);
                            r_mcnt  <= '0;
                            r_prod  <= '0;
                            r_ret   <= S_P2;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (r_mcnt != MUL_STEPS) begin
                        r_pp  <= a_part * b_part;
                        r_psh <= psh;
                    end
                    if (r_mcnt != 3'd0) begin
                        r_prod <= r_prod + pp_shifted;
                    end
                    if (r_mcnt == MUL_STEPS) begin
                        r_state <= r_ret;
                    end else begin
                        r_mcnt <= r_mcnt + 3'd1;
                    end
                end
                S_DIV: begin
                    r_drem <= dge ? ddiff[CW-1:0] : drs[CW-1:0];
                    r_q    <= {r_q[DW-2:0], dge};
                    r_dvd  <= {r_dvd[DW-2:0], 1'b0};
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= r_ret;
                    end
                end
                S_SQRT: begin
                    r_srem <= sge ? sdiff : ss;
                    r_root <= {r_root[RT_W-2:0], sge};
                    r_dvd  <= {r_dvd[DW-3:0], 2'b00};
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                // partition M2 = s^2 * (n - 1)
                S_P2: begin
                    r_ma    <= r_prod[63:0];
                    r_mb    <= 64'(r_n - 32'd1);
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_P3;
                    r_state <= S_MUL;
                end
                S_P3: begin
                    if (r_count == '0) begin
                        r_sat   <= r_sat | pm2_sat[64];
                        r_count <= CW'(r_n);
                        r_mean  <= r_pm;
                        r_sq    <= pm2_sat[63:0];
                        r_state <= S_VAR;
                    end else begin
                        r_pm2 <= pm2_sat[63:0];
                        r_neg <= neg;
                        r_ad  <= ad;
                        // count saturates at the top of its width
                        r_sat   <= r_sat | pm2_sat[64] | csum[CW];
                        r_newc  <= csum[CW] ? '1 : csum[CW-1:0];
                        r_ma    <= 64'(ad);
                        r_mb    <= 64'(r_n);
                        r_mcnt  <= '0;
                        r_prod  <= '0;
                        r_ret   <= S_M1;
                        r_state <= S_MUL;
                    end
                end
                // mean shift = delta * n / n_new
                S_M1: begin
                    r_dv    <= r_newc;
                    r_dvd   <= r_prod << 64;
                    r_q     <= '0;
                    r_drem  <= '0;
                    r_cnt   <= CNT_W'(64);
                    r_ret   <= S_M2;
                    r_state <= S_DIV;
                end
                S_M2: begin
                    r_mean  <= r_neg ? (r_mean - r_q[FW-1:0]) : (r_mean + r_q[FW-1:0]);
                    r_ma    <= 64'(r_ad);
                    r_mb    <= 64'(r_ad);
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_M3;
                    r_state <= S_MUL;
                end
                S_M3: begin
                    r_t1    <= r_prod[63:0];
                    r_ma    <= 64'(r_count);
                    r_mb    <= 64'(r_n);
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_M4;
                    r_state <= S_MUL;
                end
                // ratio = count * n / n_new, keep remainder
                S_M4: begin
                    r_dvd   <= r_prod << (DW - CW - FW);
                    r_q     <= '0;
                    r_drem  <= '0;
                    r_cnt   <= CNT_W'(CW + FW);
                    r_ret   <= S_M5;
                    r_state <= S_DIV;
                end
                S_M5: begin
                    r_ratio <= r_q[FW-1:0];
                    r_ma    <= r_t1;
                    r_mb    <= 64'(r_drem);
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_M6;
                    r_state <= S_MUL;
                end
                // fractional part: delta^2 * rem / n_new
                S_M6: begin
                    r_dvd   <= r_prod << (64 - CW);
                    r_q     <= '0;
                    r_drem  <= '0;
                    r_cnt   <= CNT_W'(64 + CW);
                    r_ret   <= S_M7;
                    r_state <= S_DIV;
                end
                S_M7: begin
                    r_ext   <= r_q[63:0];
                    r_ma    <= r_t1;
                    r_mb    <= 64'(r_ratio);
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_M8;
                    r_state <= S_MUL;
                end
                S_M8: begin
                    r_sq    <= sq_sum[63:0];
                    r_pm2   <= term_sat[63:0];
                    r_sat   <= r_sat | sq_sum[64] | term_sat[64];
                    r_state <= S_M9;
                end
                S_M9: begin
                    r_sq    <= sq_sum[63:0];
                    r_sat   <= r_sat | sq_sum[64];
                    r_count <= r_newc;
                    r_state <= S_VAR;
                end
                // variance = M2 aligned / (count - 1)
                S_VAR: begin
                    if (r_count >= CW'(2)) begin
                        r_dv    <= r_count - CW'(1);
                        r_dvd   <= {r_sq, 64'b0};
                        r_q     <= '0;
                        r_drem  <= '0;
                        r_cnt   <= CNT_W'(SQ_W);
                        r_ret   <= S_V2;
                        r_state <= S_DIV;
                    end else begin
                        r_sd    <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_V2: begin
                    r_dvd   <= r_q << (DW - SQ_W);
                    r_srem  <= '0;
                    r_root  <= '0;
                    r_cnt   <= CNT_W'(RT_W);
                    r_state <= S_SQRT;
                end
                S_FIN: begin
                    r_sd    <= (r_root > RT_W'({FW{1'b1}})) ? '1 : r_root[FW-1:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Handshake and result
    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = (r_state == S_OUT);
    assign o_out.total_count  = (r_count > CW'(rvm_pkg::OUT_COUNT_MAX)) ?
                                rvm_pkg::OUT_COUNT_MAX : rvm_pkg::OUT_COUNT_W'(r_count);
    assign o_out.total_mean   = r_mean;
    assign o_out.total_stddev = r_sd;
    assign o_out.saturated    = r_sat;

    // Checks
    `RVM_NEVER(a_busy_result, i_clk, i_rst_n, o_out.valid && i_in.ready, "input ready with result pending")
    `RVM_ASSERT(a_clear, i_clk, i_rst_n, (accept && i_in.operation) |=> (r_count == '0 && !r_sat), "clear not applied")
    `RVM_ASSERT(a_div_rem, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_drem < r_dv), "divider remainder out of range")
    `RVM_ASSERT(a_sd_small, i_clk, i_rst_n, (o_out.valid && r_count < CW'(2)) |-> (o_out.total_stddev == '0), "stddev nonzero below two samples")
endmodule

@@ verif/running_variance_merge_core_test.sv @@
// Testbench for the running variance merge core: directed and random partition merges.
`timescale 1ns / 100ps

module running_variance_merge_core_test;
    localparam logic OP_MERGE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;
    localparam logic [63:0] COUNT_SAT = (rvm_pkg::COUNT_WIDTH >= 64) ? '1 :
        ((64'd1 << rvm_pkg::COUNT_WIDTH) - 64'd1);
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [rvm_pkg::OUT_COUNT_W-1:0] total_count;
        logic [rvm_pkg::FIELD_W-1:0]     total_mean;
        logic [rvm_pkg::FIELD_W-1:0]     total_stddev;
        logic                            saturated;
    } totals_t;

    logic i_clk;
    logic i_rst_n;

    rvm_in_if  part_ch ();
    rvm_out_if tot_ch ();

    running_variance_merge_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (part_ch.sink),
        .o_out  (tot_ch.source)
    );

    // Predicted running totals
    logic [63:0] run_count;
    logic [31:0] run_mean;
    logic [63:0] run_m2;
    logic        run_sat;

    totals_t expected_totals[$];
    int      fail_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      idle_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] sat128(input logic [127:0] x, inout logic sat);
        if (x[127:64] != 0) begin
            sat = 1'b1;
            return '1;
        end
        return x[63:0];
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b,
                                            inout logic sat);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[64]) begin
            sat = 1'b1;
            return '1;
        end
        return s[63:0];
    endfunction

    // Integer square root, floor
    function automatic logic [63:0] isqrt(input logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= x) r = c;
        end
        return r;
    endfunction

    // Fold one partition transaction into the predicted totals
    task automatic merge_predict(input logic op, input logic [31:0] n,
                                 input logic [31:0] pm, input logic [31:0] ps);
        logic [63:0]  part_m2, ad, newc, shift_q, t1, rem, extra, term, sd, m2_sum;
        logic [127:0] ratio, prod, var_q;
        logic         neg;
        totals_t      t;
        sd = 0;
        if (op == OP_CLEAR) begin
            run_count = 0; run_mean = 0; run_m2 = 0; run_sat = 0;
        end else if (n != 0) begin
            prod = ({96'd0, ps} * {96'd0, ps}) * {96'd0, n - 32'd1};
            part_m2 = sat128(prod >> rvm_pkg::ALIGN_SHIFT, run_sat);
            if (run_count == 0) begin
                run_count = {32'd0, n};
                run_mean = pm;
                run_m2 = part_m2;
            end else begin
                neg = pm < run_mean;
                ad = neg ? {32'd0, run_mean - pm} : {32'd0, pm - run_mean};
                newc = run_count + {32'd0, n};
                if (newc < run_count || newc > COUNT_SAT) begin
                    newc = COUNT_SAT;
                    run_sat = 1'b1;
                end
                shift_q = (ad * {32'd0, n}) / newc;
                run_mean = neg ? run_mean - shift_q[31:0] : run_mean + shift_q[31:0];
                t1 = ad * ad;
                prod = {64'd0, run_count} * {96'd0, n};
                ratio = prod / {64'd0, newc};
                rem = 64'(prod % {64'd0, newc});
                extra = 64'(({64'd0, t1} * {64'd0, rem}) / {64'd0, newc});
                prod = {64'd0, t1} * {64'd0, ratio[63:0]} + {64'd0, extra};
                term = sat128(prod >> rvm_pkg::ALIGN_SHIFT, run_sat);
                m2_sum = add_sat(run_m2, part_m2, run_sat);
                run_m2 = add_sat(m2_sum, term, run_sat);
                run_count = newc;
            end
        end
        if (run_count >= 2) begin
            var_q = ({64'd0, run_m2} << rvm_pkg::ALIGN_SHIFT) / {64'd0, run_count - 64'd1};
            sd = isqrt(var_q);
            if (sd > 64'hFFFF_FFFF) sd = 64'hFFFF_FFFF;
        end
        t.total_count = (run_count > {16'd0, rvm_pkg::OUT_COUNT_MAX}) ? rvm_pkg::OUT_COUNT_MAX
                        : run_count[rvm_pkg::OUT_COUNT_W-1:0];
        t.total_mean = run_mean;
        t.total_stddev = sd[31:0];
        t.saturated = run_sat;
        expected_totals.push_back(t);
    endtask

    // Send one partition transaction, with random idle before it
    task automatic send_partition(input logic op, input logic [31:0] n,
                                  input logic [31:0] pm, input logic [31:0] ps);
        while ($urandom_range(99) < send_idle_pct) begin
            part_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        part_ch.valid <= 1'b1;
        part_ch.operation <= op;
        part_ch.partition_count <= n;
        part_ch.partition_mean <= pm;
        part_ch.partition_stddev <= ps;
        @(posedge i_clk);
        while (!part_ch.ready) @(posedge i_clk);
        merge_predict(op, n, pm, ps);
    endtask

    // Receiver stalls and result checks
    always @(posedge i_clk) begin
        totals_t want;
        if (!i_rst_n) begin
            tot_ch.ready <= 1'b0;
        end else begin
            if (tot_ch.valid && tot_ch.ready) begin
                if (expected_totals.size() == 0) begin
                    $error("result with no transaction outstanding");
                    fail_count++;
                end else begin
                    want = expected_totals.pop_front();
                    if (tot_ch.total_count !== want.total_count) begin
                        $error("total_count exp %0d got %0d", want.total_count,
                               tot_ch.total_count);
                        fail_count++;
                    end
                    if (tot_ch.total_mean !== want.total_mean) begin
                        $error("total_mean exp %h got %h", want.total_mean,
                               tot_ch.total_mean);
                        fail_count++;
                    end
                    if (tot_ch.total_stddev !== want.total_stddev) begin
                        $error("total_stddev exp %h got %h", want.total_stddev,
                               tot_ch.total_stddev);
                        fail_count++;
                    end
                    if (tot_ch.saturated !== want.saturated) begin
                        $error("saturated exp %b got %b", want.saturated,
                               tot_ch.saturated);
                        fail_count++;
                    end
                end
            end
            tot_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (part_ch.valid && part_ch.ready) || (tot_ch.valid && tot_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_partition(OP_MERGE, 32'd0, 32'h1234_5678, 32'h1);
        send_partition(OP_MERGE, 32'd1, 32'h0001_0000, 32'd0);
        send_partition(OP_MERGE, 32'd1, 32'h0003_0000, 32'd0);
        send_partition(OP_MERGE, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_partition(OP_MERGE, 32'd10, 32'h0000_8000, 32'h0002_0000);
        send_partition(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_partition(OP_MERGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_partition(OP_MERGE, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_partition(OP_MERGE, 32'd1, 32'hFFFF_FFFF, 32'd0);
        send_partition(OP_CLEAR, 32'd0, 32'd0, 32'd0);
        send_partition(OP_MERGE, 32'd2, 32'd0, 32'd0);
        send_partition(OP_MERGE, 32'd2, 32'hFFFF_FFFF, 32'd0);
        send_partition(OP_CLEAR, 32'd0, 32'd0, 32'd0);
        // Large partitions: full-size counts with means near the midpoint
        for (int k = 0; k < 6; k++)
            send_partition(OP_MERGE, 32'hFFFF_FFFF, 32'h8000_0000 + k, 32'h0001_0000);
        send_partition(OP_CLEAR, 32'd0, 32'd0, 32'd0);
    endtask

    task automatic test_random(input int items);
        for (int k = 0; k < items; k++) begin
            if ($urandom_range(39) == 0)
                send_partition(OP_CLEAR, $urandom, $urandom, $urandom);
            else if ($urandom_range(9) == 0)
                send_partition(OP_MERGE, 32'd0, $urandom, $urandom);
            else
                send_partition(OP_MERGE, ($urandom_range(3) == 0) ? rand_word()
                               : $urandom_range(1000), rand_word(), rand_word());
        end
    endtask

    task automatic wait_drained();
        while (expected_totals.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        send_idle_pct = 11;
        recv_idle_pct = 50;
        i_rst_n = 1'b0;
        part_ch.valid = 1'b0;
        part_ch.operation = OP_MERGE;
        part_ch.partition_count = '0;
        part_ch.partition_mean = '0;
        part_ch.partition_stddev = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(520);
        send_idle_pct = 50;
        recv_idle_pct = 11;
        test_random(520);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(540);
        part_ch.valid <= 1'b0;
        wait_drained();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
